// ----- src/ysr_pkg.sv -----
// Shared types, codes and colour conversion constants for the YUYV scaler.
package ysr_pkg;

  // Request codes carried on the action field.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Sequencer states for one destination pixel read.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_CONV,
    ST_SUM
  } ysr_state_t;

  localparam int PROD_W = 19;
  localparam int SUM_W  = 20;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // BT.601 integer coefficients.
  localparam logic signed [10:0] COEF_Y  = 11'sd298;
  localparam logic signed [10:0] COEF_RV = 11'sd409;
  localparam logic signed [10:0] COEF_GU = 11'sd100;
  localparam logic signed [10:0] COEF_GV = 11'sd208;
  localparam logic signed [10:0] COEF_BU = 11'sd516;

  localparam sum_t ROUND = 20'sd128;

  localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

  // Floor the sum by 256 and clamp the result to 0..255.
  function automatic logic [7:0] clamp_channel(input sum_t s);
    logic [7:0] q;
    if (s[SUM_W-1]) begin
      q = 8'd0;
    end else if (|s[SUM_W-2:16]) begin
      q = 8'hFF;
    end else begin
      q = s[15:8];
    end
    return q;
  endfunction

endpackage

// ----- src/ysr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ysr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/yuyv_scale_to_rgb565.sv -----
// Top level: YUYV frame store with nearest-neighbour scaling to RGB565 pixels.
//
// The block holds one source frame of YUYV macropixels in a single on-chip
// memory of ceil(SRC_WIDTH*SRC_HEIGHT/2) words of 32 bits, with luma_even in
// byte 0, U in byte 1, luma_odd in byte 2 and V in byte 3. A write request
// stores one macropixel; the next request is taken in the following cycle,
// and an index at or beyond the store depth is dropped. A read request names
// a destination pixel; its column and row saturate to the destination size,
// are scaled to a source pixel by multiplying with the source size and
// dividing by the destination size through a reciprocal constant, and the
// matching macropixel is fetched and converted with BT.601 integer
// coefficients. A read runs through the scale multiply, reciprocal multiply,
// address multiply, the memory's registered read and the two colour
// conversion steps one after the other; the last step loads the output
// register, waiting while it is full and stalled, and only then is the next
// request taken. While a read is in progress the request side is stalled, so
// a later write can never overtake an earlier read of the same entry. A
// finished pixel sits in an output register, so the block accepts the next
// request while the previous pixel is still waiting to be taken. Reading an
// entry that was never written returns an undefined pixel. The memory has
// no reset and needs no clearing pass.
module yuyv_scale_to_rgb565 #(
  parameter int SRC_WIDTH  = 640,
  parameter int SRC_HEIGHT = 480,
  parameter int DST_WIDTH  = 480,
  parameter int DST_HEIGHT = 800
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        action,
  input  logic [17:0] pair_index,
  input  logic [7:0]  luma_even,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  luma_odd,
  input  logic [7:0]  chroma_red,
  input  logic [8:0]  dest_col,
  input  logic [9:0]  dest_row,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] pixel_rgb565
);

  // Store geometry.
  localparam int DEPTH  = (SRC_WIDTH * SRC_HEIGHT + 1) / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIX_W  = $clog2(SRC_WIDTH * SRC_HEIGHT);

  // Source coordinate widths.
  localparam int SX_W = $clog2(SRC_WIDTH);
  localparam int SY_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

  // Scaled numerators col*SRC_WIDTH and row*SRC_HEIGHT.
  localparam int XN_W = 9 + $clog2(SRC_WIDTH + 1);
  localparam int YN_W = 10 + $clog2(SRC_HEIGHT + 1);

  // Reciprocal constants: ceil(2^K / D) with K = N + ceil(log2 D) gives an
  // exact floor quotient for every numerator below 2^N.
  localparam int KX = XN_W + $clog2(DST_WIDTH);
  localparam int KY = YN_W + $clog2(DST_HEIGHT);
  localparam longint RECIP_X_L =
    ((longint'(1) << KX) + longint'(DST_WIDTH) - 1) / longint'(DST_WIDTH);
  localparam longint RECIP_Y_L =
    ((longint'(1) << KY) + longint'(DST_HEIGHT) - 1) / longint'(DST_HEIGHT);
  localparam int MX_W = XN_W + 2;
  localparam int MY_W = YN_W + 2;
  localparam logic [MX_W-1:0] RECIP_X = MX_W'(RECIP_X_L);
  localparam logic [MY_W-1:0] RECIP_Y = MY_W'(RECIP_Y_L);
  localparam int XP_W = (XN_W + MX_W > KX + SX_W) ? XN_W + MX_W : KX + SX_W;
  localparam int YP_W = (YN_W + MY_W > KY + SY_W) ? YN_W + MY_W : KY + SY_W;

  ysr_pkg::ysr_state_t state, state_next;

  logic              ram_we;
  logic              wr_in_range;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       rd_data;
  logic              rsp_load;
  logic              read_accept;

  // Per-request working registers.
  logic [8:0]        col_c;
  logic [9:0]        row_c;
  logic [XN_W-1:0]   xn;
  logic [YN_W-1:0]   yn;
  logic [SX_W-1:0]   sx;
  logic [SY_W-1:0]   sy;
  logic [ADDR_W-1:0] rd_addr;
  logic              odd;
  ysr_pkg::prod_t    prod_y, prod_rv, prod_gu, prod_gv, prod_bu;

  logic [XP_W-1:0]   xprod;
  logic [YP_W-1:0]   yprod;
  logic [PIX_W-1:0]  pix;
  logic [7:0]        luma;
  logic signed [8:0] c_val, d_val, e_val;
  ysr_pkg::sum_t     sum_r, sum_g, sum_b;
  logic [7:0]        ch_r, ch_g, ch_b;

  // Write path: a macropixel goes straight into the store.
  assign wr_in_range = 32'(pair_index) < 32'(DEPTH);
  assign wr_addr     = ADDR_W'(pair_index);
  assign wr_data     = {chroma_red, luma_odd, chroma_blue, luma_even};

  assign read_accept = (state == ysr_pkg::ST_IDLE) && req_valid &&
                       (action == ysr_pkg::ACT_READ);

  ysr_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Sequencer: state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ysr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and control. Requests are only taken when idle.
  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    ram_we     = 1'b0;
    rsp_load   = 1'b0;
    case (state)
      ysr_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (action == ysr_pkg::ACT_READ) begin
            state_next = ysr_pkg::ST_SCALE;
          end else begin
            ram_we = wr_in_range;
          end
        end
      end
      ysr_pkg::ST_SCALE: state_next = ysr_pkg::ST_DIV;
      ysr_pkg::ST_DIV:   state_next = ysr_pkg::ST_ADDR;
      ysr_pkg::ST_ADDR:  state_next = ysr_pkg::ST_READ;
      ysr_pkg::ST_READ:  state_next = ysr_pkg::ST_CONV;
      ysr_pkg::ST_CONV:  state_next = ysr_pkg::ST_SUM;
      ysr_pkg::ST_SUM: begin
        // Hand over to the output register once it is free or being emptied.
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ysr_pkg::ST_IDLE;
        end
      end
      default: state_next = ysr_pkg::ST_IDLE;
    endcase
  end

  // Datapath arithmetic between the working registers.
  always_comb begin
    xprod = XP_W'(xn) * XP_W'(RECIP_X);
    yprod = YP_W'(yn) * YP_W'(RECIP_Y);
    pix   = PIX_W'(sy) * PIX_W'(SRC_WIDTH) + PIX_W'(sx);
    luma  = odd ? rd_data[23:16] : rd_data[7:0];
    c_val = $signed({1'b0, luma}) - ysr_pkg::LUMA_OFFSET;
    d_val = $signed({1'b0, rd_data[15:8]}) - ysr_pkg::CHROMA_OFFSET;
    e_val = $signed({1'b0, rd_data[31:24]}) - ysr_pkg::CHROMA_OFFSET;
    sum_r = ysr_pkg::sum_t'(prod_y) + ysr_pkg::sum_t'(prod_rv) + ysr_pkg::ROUND;
    sum_g = ysr_pkg::sum_t'(prod_y) - ysr_pkg::sum_t'(prod_gu)
          - ysr_pkg::sum_t'(prod_gv) + ysr_pkg::ROUND;
    sum_b = ysr_pkg::sum_t'(prod_y) + ysr_pkg::sum_t'(prod_bu) + ysr_pkg::ROUND;
    ch_r  = ysr_pkg::clamp_channel(sum_r);
    ch_g  = ysr_pkg::clamp_channel(sum_g);
    ch_b  = ysr_pkg::clamp_channel(sum_b);
  end

  // Working registers, each loaded in its own step of the sequence.
  always_ff @(posedge clk) begin
    if (read_accept) begin
      // Out-of-range destination coordinates saturate to the last one.
      col_c <= (32'(dest_col) >= 32'(DST_WIDTH))  ? 9'(DST_WIDTH - 1)  : dest_col;
      row_c <= (32'(dest_row) >= 32'(DST_HEIGHT)) ? 10'(DST_HEIGHT - 1) : dest_row;
    end
    if (state == ysr_pkg::ST_SCALE) begin
      xn <= XN_W'(col_c) * XN_W'(SRC_WIDTH);
      yn <= YN_W'(row_c) * YN_W'(SRC_HEIGHT);
    end
    if (state == ysr_pkg::ST_DIV) begin
      sx <= xprod[KX +: SX_W];
      sy <= yprod[KY +: SY_W];
    end
    if (state == ysr_pkg::ST_ADDR) begin
      rd_addr <= ADDR_W'(pix >> 1);
      odd     <= sx[0];
    end
    if (state == ysr_pkg::ST_CONV) begin
      // Both operands are widened first so that the product keeps every bit.
      prod_y  <= ysr_pkg::prod_t'(ysr_pkg::COEF_Y)  * ysr_pkg::prod_t'(c_val);
      prod_rv <= ysr_pkg::prod_t'(ysr_pkg::COEF_RV) * ysr_pkg::prod_t'(e_val);
      prod_gu <= ysr_pkg::prod_t'(ysr_pkg::COEF_GU) * ysr_pkg::prod_t'(d_val);
      prod_gv <= ysr_pkg::prod_t'(ysr_pkg::COEF_GV) * ysr_pkg::prod_t'(e_val);
      prod_bu <= ysr_pkg::prod_t'(ysr_pkg::COEF_BU) * ysr_pkg::prod_t'(d_val);
    end
    if (rsp_load) begin
      pixel_rgb565 <= {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
    end
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // A new pixel only ever comes from the final conversion step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ysr_pkg::ST_SUM)
    else $error("pixel presented without passing the conversion step");

  // An accepted read always starts the sequence in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && action == ysr_pkg::ACT_READ)
      |=> state == ysr_pkg::ST_SCALE)
    else $error("accepted read did not start the sequence");

  // An accepted write leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && action == ysr_pkg::ACT_WRITE)
      |=> state == ysr_pkg::ST_IDLE)
    else $error("accepted write disturbed the sequencer");

  // The store is never written while a read is in progress.
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ysr_pkg::ST_IDLE && req_valid))
    else $error("store written during a read");

  // A read step only leads to the conversion step, so its data is not lost.
  assert property (@(posedge clk) disable iff (rst)
    state == ysr_pkg::ST_READ |=> state == ysr_pkg::ST_CONV)
    else $error("memory read data not consumed");
`endif

endmodule

// ----- dv/ysr_pixel_checker.sv -----
// Checker that mirrors the YUYV frame store and compares every returned RGB565 pixel.
module ysr_pixel_checker #(
  parameter int SRC_WIDTH  = 640,
  parameter int SRC_HEIGHT = 480,
  parameter int DST_WIDTH  = 480,
  parameter int DST_HEIGHT = 800
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic        action,
  input  logic [17:0] pair_index,
  input  logic [7:0]  luma_even,
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  luma_odd,
  input  logic [7:0]  chroma_red,
  input  logic [8:0]  dest_col,
  input  logic [9:0]  dest_row,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [15:0] pixel_rgb565,
  output int          mismatch_count,
  output int          pixels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = (SRC_WIDTH * SRC_HEIGHT + 1) / 2;

  // Shadow of the frame store: V, odd luma, U, even luma from high byte to low.
  logic [31:0] frame_copy [STORE_DEPTH];
  logic [15:0] expected_pixels [$];

  function automatic logic [7:0] clamp_byte(input int s);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic logic [15:0] yuv_to_rgb565(input logic [7:0] y, u, v);
    int c, d, e;
    logic [7:0] r, g, b;
    c = int'(y) - 16;
    d = int'(u) - 128;
    e = int'(v) - 128;
    r = clamp_byte((298 * c + 409 * e + 128) >>> 8);
    g = clamp_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
    b = clamp_byte((298 * c + 516 * d + 128) >>> 8);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] scaled_pixel(input logic [8:0] col, input logic [9:0] row);
    int cc, rr, sx, sy, pix;
    logic [31:0] word;
    cc = (col >= DST_WIDTH) ? DST_WIDTH - 1 : int'(col);
    rr = (row >= DST_HEIGHT) ? DST_HEIGHT - 1 : int'(row);
    sx = cc * SRC_WIDTH / DST_WIDTH;
    sy = rr * SRC_HEIGHT / DST_HEIGHT;
    pix = sy * SRC_WIDTH + sx;
    word = frame_copy[pix / 2];
    return yuv_to_rgb565(sx[0] ? word[23:16] : word[7:0], word[15:8], word[31:24]);
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want, got);
    if (mismatch_count < 10) begin
      $display("%0t ns: %s: expected %04h, got %04h", $time, what, want, got);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatch_count = 0;
      expected_pixels.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("pixel with no read outstanding", 16'hxxxx, pixel_rgb565);
        end else if (pixel_rgb565 !== expected_pixels[0]) begin
          note_mismatch("pixel_rgb565 mismatch", expected_pixels[0], pixel_rgb565);
          void'(expected_pixels.pop_front());
        end else begin
          void'(expected_pixels.pop_front());
        end
      end
      if (req_valid && !req_stall) begin
        if (action == ysr_pkg::ACT_READ) begin
          expected_pixels.push_back(scaled_pixel(dest_col, dest_row));
        end else if (pair_index < STORE_DEPTH) begin
          frame_copy[pair_index] = {chroma_red, luma_odd, chroma_blue, luma_even};
        end
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

// ----- dv/yuyv_scale_to_rgb565_tb.sv -----
// Testbench top for the YUYV frame store and RGB565 scaler: stimulus and verdict.
module yuyv_scale_to_rgb565_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SRC_WIDTH   = 640;
  localparam int SRC_HEIGHT  = 480;
  localparam int DST_WIDTH   = 480;
  localparam int DST_HEIGHT  = 800;
  localparam int STORE_DEPTH = (SRC_WIDTH * SRC_HEIGHT + 1) / 2;
  localparam int RANDOM_PER_PHASE = 350;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        action = ysr_pkg::ACT_WRITE;
  logic [17:0] pair_index = '0;
  logic [7:0]  luma_even = '0;
  logic [7:0]  chroma_blue = '0;
  logic [7:0]  luma_odd = '0;
  logic [7:0]  chroma_red = '0;
  logic [8:0]  dest_col = '0;
  logic [9:0]  dest_row = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [15:0] pixel_rgb565;

  int mismatch_count;
  int pixels_pending;

  // Percentages that the sender idles and the receiver stalls per cycle.
  int idle_pct = 0;
  int stall_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int hold_requests = 0;

  // Which macropixels have been written since reset; reads are steered so that
  // they only ever land on written entries, since an unwritten entry reads back
  // as an undefined pixel.
  bit pair_written [STORE_DEPTH];
  // Recently read macropixels, so that later writes overwrite entries that are
  // read again.
  int recent_pairs [$];

  always #4 clk = ~clk;

  yuyv_scale_to_rgb565 #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .DST_WIDTH (DST_WIDTH),
    .DST_HEIGHT(DST_HEIGHT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .action      (action),
    .pair_index  (pair_index),
    .luma_even   (luma_even),
    .chroma_blue (chroma_blue),
    .luma_odd    (luma_odd),
    .chroma_red  (chroma_red),
    .dest_col    (dest_col),
    .dest_row    (dest_row),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .pixel_rgb565(pixel_rgb565)
  );

  ysr_pixel_checker #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .DST_WIDTH (DST_WIDTH),
    .DST_HEIGHT(DST_HEIGHT)
  ) u_chk (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .action        (action),
    .pair_index    (pair_index),
    .luma_even     (luma_even),
    .chroma_blue   (chroma_blue),
    .luma_odd      (luma_odd),
    .chroma_red    (chroma_red),
    .dest_col      (dest_col),
    .dest_row      (dest_row),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .pixel_rgb565  (pixel_rgb565),
    .mismatch_count(mismatch_count),
    .pixels_pending(pixels_pending)
  );

  // The macropixel that a destination pixel lands on, after saturation and
  // nearest-neighbour scaling. Used only to decide what must be written first.
  function automatic int source_pair(input int col, input int row);
    int cc, rr;
    cc = (col >= DST_WIDTH) ? DST_WIDTH - 1 : col;
    rr = (row >= DST_HEIGHT) ? DST_HEIGHT - 1 : row;
    return ((rr * SRC_HEIGHT / DST_HEIGHT) * SRC_WIDTH + cc * SRC_WIDTH / DST_WIDTH) / 2;
  endfunction

  // Random colour byte, leaning towards the extremes now and then so that the
  // clamping on every channel is exercised often.
  function automatic logic [7:0] colour_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one request and returns once it has been accepted. The payload is
  // only changed when a new request is offered, so a stalled request holds.
  task automatic offer_request(input logic act, input logic [17:0] idx,
                               input logic [7:0] ye, u, yo, v,
                               input logic [8:0] col, input logic [9:0] row);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    action      <= act;
    pair_index  <= idx;
    luma_even   <= ye;
    chroma_blue <= u;
    luma_odd    <= yo;
    chroma_red  <= v;
    dest_col    <= col;
    dest_row    <= row;
    do @(posedge clk); while (req_stall);
  endtask

  // A write request; the destination fields are don't-care and carry noise.
  task automatic write_pair(input int idx, input logic [7:0] ye, u, yo, v);
    offer_request(ysr_pkg::ACT_WRITE, 18'(idx), ye, u, yo, v,
                  9'($urandom_range(511)), 10'($urandom_range(1023)));
    if (idx < STORE_DEPTH) begin
      pair_written[idx] = 1'b1;
    end
  endtask

  // A read request. Where the source macropixel has not been written yet, a
  // write with random content goes ahead of it, which makes a well-formed
  // write-then-read sequence.
  task automatic read_pixel(input int col, input int row);
    int p;
    p = source_pair(col, row);
    if (!pair_written[p]) begin
      write_pair(p, colour_byte(), colour_byte(), colour_byte(), colour_byte());
    end
    offer_request(ysr_pkg::ACT_READ, 18'($urandom_range(262143)), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 9'(col), 10'(row));
    recent_pairs.push_back(p);
    if (recent_pairs.size() > 16) begin
      void'(recent_pairs.pop_front());
    end
  endtask

  // One random request. Reads mostly stay inside the destination frame, with
  // some beyond it to hit the saturation. Writes either overwrite an entry
  // that was read recently, land anywhere in the store, or fall beyond the
  // end of the store, where they must be dropped.
  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      read_pixel(($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(479),
                 ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(799));
    end else if (pick < 75 && recent_pairs.size() > 0) begin
      write_pair(recent_pairs[$urandom_range(recent_pairs.size() - 1)],
                 colour_byte(), colour_byte(), colour_byte(), colour_byte());
    end else if (pick < 92) begin
      write_pair($urandom_range(STORE_DEPTH - 1),
                 colour_byte(), colour_byte(), colour_byte(), colour_byte());
    end else begin
      write_pair($urandom_range(262143, STORE_DEPTH),
                 colour_byte(), colour_byte(), colour_byte(), colour_byte());
    end
  endtask

  // Receiver: stalls at random at the current rate, and on request holds off
  // for a long stretch so that the block backs up into its request side.
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        rsp_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Hard limit on the run, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle  = '{0, 81, 0, 34};
    phase_stall = '{0, 0, 81, 34};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Entry 0 holds black on the even pixel and white on the
    // odd one; the last entry of the store is filled with saturated values.
    write_pair(0, 8'd16, 8'd128, 8'd235, 8'd128);
    read_pixel(0, 0);
    read_pixel(1, 0);
    write_pair(STORE_DEPTH - 1, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    read_pixel(DST_WIDTH - 1, DST_HEIGHT - 1);
    // Destination beyond the frame saturates to the last row and column.
    read_pixel(511, 1023);
    read_pixel(511, 0);
    read_pixel(0, 1023);
    // Writes past the end of the store are dropped and must not alias onto
    // the entries at either end.
    write_pair(STORE_DEPTH, 8'h00, 8'h00, 8'h00, 8'h00);
    write_pair(262143, 8'h00, 8'h00, 8'h00, 8'h00);
    read_pixel(0, 0);
    read_pixel(DST_WIDTH - 1, DST_HEIGHT - 1);
    // Conversion extremes: every channel clamped low and high, both lumas.
    write_pair(0, 8'h00, 8'h00, 8'hFF, 8'h00);
    read_pixel(0, 0);
    read_pixel(1, 0);
    write_pair(0, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    read_pixel(0, 0);
    read_pixel(1, 0);
    write_pair(0, 8'h80, 8'hFF, 8'h80, 8'h00);
    read_pixel(0, 0);
    read_pixel(1, 0);
    write_pair(0, 8'h80, 8'h00, 8'h80, 8'hFF);
    read_pixel(0, 0);
    read_pixel(1, 0);

    // Back-pressure: the receiver holds off for a long stretch while reads
    // keep coming, so the output register fills and the request side stalls.
    hold_requests++;
    repeat (40) read_pixel($urandom_range(479), $urandom_range(799));

    // Random part over the four phases of idling and stalling.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (RANDOM_PER_PHASE) random_request();
    end

    req_valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;

    // Drain the outstanding pixels, then allow a read's worth of cycles more
    // so that any stray pixel would still be caught.
    while (pixels_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
